### rtl/trm_pkg.sv
// Shared types, opcodes and the microcode table of the register machine executor.
package trm_pkg;

  // Instruction opcodes
  typedef enum logic [3:0] {
    CMD_IN    = 4'd0,
    CMD_OUT   = 4'd1,
    CMD_MOVI  = 4'd2,
    CMD_MOVR  = 4'd3,
    CMD_LDIND = 4'd4,
    CMD_ADD   = 4'd5,
    CMD_SUB   = 4'd6,
    CMD_MUL   = 4'd7,
    CMD_DIV   = 4'd8,
    CMD_INC   = 4'd9,
    CMD_DEC   = 4'd10,
    CMD_ST    = 4'd11,
    CMD_LD    = 4'd12
  } cmd_e;

  // Error codes reported with each result
  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_ADDR = 2'd2
  } err_e;

  // Microcode fields
  typedef enum logic {
    RS_SRC,
    RS_DST
  } rsel_e;

  typedef enum logic [1:0] {
    LAT_NONE,
    LAT_A,
    LAT_B
  } lat_e;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_VAL,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_INC,
    ALU_DEC,
    ALU_DIVI,
    ALU_DIVS,
    ALU_DIVF
  } alu_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_RES,
    WB_VAL,
    WB_B,
    WB_MEM
  } wb_e;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_RD_IND,
    MEM_RD_ADR,
    MEM_WR
  } mem_e;

  typedef enum logic [1:0] {
    RV_ZERO,
    RV_B,
    RV_MEM
  } rv_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_RZERO,
    JC_OOB,
    JC_LOOP
  } jc_e;

  localparam int unsigned UA_W      = 6;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned RES_W     = 16;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned DCNT_W    = 3;

  typedef logic [UA_W-1:0] uaddr_t;

  // Program entry points
  localparam uaddr_t UA_IN    = 6'd0;
  localparam uaddr_t UA_OUT   = 6'd2;
  localparam uaddr_t UA_MOVI  = 6'd4;
  localparam uaddr_t UA_MOVR  = 6'd5;
  localparam uaddr_t UA_LDIND = 6'd7;
  localparam uaddr_t UA_ADD   = 6'd10;
  localparam uaddr_t UA_SUB   = 6'd14;
  localparam uaddr_t UA_MUL   = 6'd18;
  localparam uaddr_t UA_INC   = 6'd22;
  localparam uaddr_t UA_DEC   = 6'd25;
  localparam uaddr_t UA_DIV   = 6'd28;
  localparam uaddr_t UA_EDIV  = 6'd33;
  localparam uaddr_t UA_ST    = 6'd34;
  localparam uaddr_t UA_LD    = 6'd36;
  localparam uaddr_t UA_EADR  = 6'd38;
  localparam uaddr_t UA_NOP   = 6'd39;

  // One control word
  typedef struct packed {
    rsel_e  rsel;
    lat_e   lat;
    alu_e   alu;
    wb_e    wb;
    mem_e   mem;
    rv_e    rv;
    err_e   err;
    jc_e    jc;
    uaddr_t target;
    logic   done;
  } cw_t;

  localparam cw_t CW_IDLE = '{
    rsel:   RS_SRC,
    lat:    LAT_NONE,
    alu:    ALU_NONE,
    wb:     WB_NONE,
    mem:    MEM_NONE,
    rv:     RV_ZERO,
    err:    ERR_OK,
    jc:     JC_NONE,
    target: UA_NOP,
    done:   1'b0
  };

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic rd_zero;
    logic addr_oob;
  } status_t;

  typedef struct packed {
    logic uf;
    logic of;
    logic cf;
    logic zf;
  } flags_t;

  // Result of one instruction
  typedef struct packed {
    err_e                error;
    flags_t              flags;
    logic [DATA_W-1:0]   read_value;
  } result_t;

  // Operand fields of one instruction
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [7:0]        address;
    logic [2:0]        dst_reg;
    logic [2:0]        src_reg;
  } item_t;

  // Map an opcode to its program
  function automatic uaddr_t entry_of(input logic [3:0] cmd);
    uaddr_t ua;
    unique case (cmd_e'(cmd))
      CMD_IN:    ua = UA_IN;
      CMD_OUT:   ua = UA_OUT;
      CMD_MOVI:  ua = UA_MOVI;
      CMD_MOVR:  ua = UA_MOVR;
      CMD_LDIND: ua = UA_LDIND;
      CMD_ADD:   ua = UA_ADD;
      CMD_SUB:   ua = UA_SUB;
      CMD_MUL:   ua = UA_MUL;
      CMD_DIV:   ua = UA_DIV;
      CMD_INC:   ua = UA_INC;
      CMD_DEC:   ua = UA_DEC;
      CMD_ST:    ua = UA_ST;
      CMD_LD:    ua = UA_LD;
      default:   ua = UA_NOP;
    endcase
    return ua;
  endfunction

  // Microcode ROM
  function automatic cw_t ucode(input uaddr_t ua);
    cw_t w;
    w = CW_IDLE;
    unique case (ua)
      UA_IN:            w.alu = ALU_VAL;
      UA_IN + 6'd1:     begin w.wb = WB_RES; w.done = 1'b1; end
      UA_OUT:           begin w.rsel = RS_SRC; w.lat = LAT_B; end
      UA_OUT + 6'd1:    begin w.rv = RV_B; w.done = 1'b1; end
      UA_MOVI:          begin w.wb = WB_VAL; w.done = 1'b1; end
      UA_MOVR:          begin w.rsel = RS_SRC; w.lat = LAT_B; end
      UA_MOVR + 6'd1:   begin w.wb = WB_B; w.done = 1'b1; end
      UA_LDIND:         begin w.rsel = RS_SRC; w.lat = LAT_B; end
      UA_LDIND + 6'd1:  w.mem = MEM_RD_IND;
      UA_LDIND + 6'd2:  begin w.wb = WB_MEM; w.done = 1'b1; end
      UA_ADD:           begin w.rsel = RS_DST; w.lat = LAT_A; end
      UA_ADD + 6'd1:    begin w.rsel = RS_SRC; w.lat = LAT_B; end
      UA_ADD + 6'd2:    w.alu = ALU_ADD;
      UA_ADD + 6'd3:    begin w.wb = WB_RES; w.done = 1'b1; end
      UA_SUB:           begin w.rsel = RS_DST; w.lat = LAT_A; end
      UA_SUB + 6'd1:    begin w.rsel = RS_SRC; w.lat = LAT_B; end
      UA_SUB + 6'd2:    w.alu = ALU_SUB;
      UA_SUB + 6'd3:    begin w.wb = WB_RES; w.done = 1'b1; end
      UA_MUL:           begin w.rsel = RS_DST; w.lat = LAT_A; end
      UA_MUL + 6'd1:    begin w.rsel = RS_SRC; w.lat = LAT_B; end
      UA_MUL + 6'd2:    w.alu = ALU_MUL;
      UA_MUL + 6'd3:    begin w.wb = WB_RES; w.done = 1'b1; end
      UA_INC:           begin w.rsel = RS_DST; w.lat = LAT_A; end
      UA_INC + 6'd1:    w.alu = ALU_INC;
      UA_INC + 6'd2:    begin w.wb = WB_RES; w.done = 1'b1; end
      UA_DEC:           begin w.rsel = RS_DST; w.lat = LAT_A; end
      UA_DEC + 6'd1:    w.alu = ALU_DEC;
      UA_DEC + 6'd2:    begin w.wb = WB_RES; w.done = 1'b1; end
      UA_DIV:           begin w.rsel = RS_DST; w.lat = LAT_A; end
      UA_DIV + 6'd1:    begin
        w.rsel = RS_SRC; w.lat = LAT_B; w.alu = ALU_DIVI;
        w.jc = JC_RZERO; w.target = UA_EDIV;
      end
      UA_DIV + 6'd2:    begin w.alu = ALU_DIVS; w.jc = JC_LOOP; w.target = UA_DIV + 6'd2; end
      UA_DIV + 6'd3:    w.alu = ALU_DIVF;
      UA_DIV + 6'd4:    begin w.wb = WB_RES; w.done = 1'b1; end
      UA_EDIV:          begin w.err = ERR_DIV0; w.done = 1'b1; end
      UA_ST:            begin w.jc = JC_OOB; w.target = UA_EADR; end
      UA_ST + 6'd1:     begin w.mem = MEM_WR; w.done = 1'b1; end
      UA_LD:            begin w.mem = MEM_RD_ADR; w.jc = JC_OOB; w.target = UA_EADR; end
      UA_LD + 6'd1:     begin w.rv = RV_MEM; w.done = 1'b1; end
      UA_EADR:          begin w.err = ERR_ADDR; w.done = 1'b1; end
      default:          w.done = 1'b1;
    endcase
    return w;
  endfunction

endpackage

### rtl/trm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/trm_useq.sv
// Microcode sequencer: step counter, control ROM, loop counter and jumps.
module trm_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [3:0]       cmd_i,
  input  trm_pkg::status_t st_i,
  input  logic             out_stall_i,
  output logic             busy_o,
  output logic             step_en_o,
  output trm_pkg::cw_t     cw_o
);

  logic                          busy_q, busy_d;
  trm_pkg::uaddr_t               upc_q, upc_d;
  logic [trm_pkg::DCNT_W-1:0]    cnt_q, cnt_d;
  trm_pkg::cw_t                  cw;
  logic                          step_en;
  logic                          jump;

  // Fetch the control word of the current step
  assign cw = trm_pkg::ucode(upc_q);

  // Hold the final step while the result register is still occupied
  assign step_en = busy_q && !(cw.done && out_stall_i);

  // Evaluate the jump condition
  always_comb begin
    unique case (cw.jc)
      trm_pkg::JC_RZERO: jump = st_i.rd_zero;
      trm_pkg::JC_OOB:   jump = st_i.addr_oob;
      trm_pkg::JC_LOOP:  jump = (cnt_q != trm_pkg::DCNT_W'(trm_pkg::DIV_STEPS - 1));
      default:           jump = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      upc_d  = trm_pkg::entry_of(cmd_i);
      cnt_d  = '0;
    end else if (step_en) begin
      if (cw.done) begin
        busy_d = 1'b0;
      end
      upc_d = jump ? cw.target : upc_q + trm_pkg::UA_W'(1);
      cnt_d = (cw.jc == trm_pkg::JC_LOOP) ? cnt_q + trm_pkg::DCNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= trm_pkg::UA_NOP;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
      cnt_q  <= cnt_d;
    end
  end

  assign busy_o    = busy_q;
  assign step_en_o = step_en;
  assign cw_o      = cw;

endmodule

### rtl/trm_datapath.sv
// Datapath: register file, ALU, serial divider, flags and data memory.
module trm_datapath #(
  parameter int unsigned MEM_DEPTH = 64,
  parameter int unsigned REG_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  trm_pkg::item_t   item_i,
  input  trm_pkg::cw_t     cw_i,
  input  logic             step_en_i,
  output trm_pkg::status_t st_o,
  output trm_pkg::result_t res_o
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned RW = $clog2(REG_COUNT);
  localparam int unsigned DW = trm_pkg::DATA_W;
  localparam int unsigned FW = trm_pkg::RES_W;

  // Remainder by a constant through eight compare-and-subtract steps
  function automatic logic [DW-1:0] mod_by(input logic [DW-1:0] v, input logic [8:0] m);
    logic [16:0] r;
    logic [16:0] t;
    r = {9'd0, v};
    for (int k = 7; k >= 0; k--) begin
      t = {8'd0, m} << k;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r[DW-1:0];
  endfunction

  logic [RW-1:0]        src_q, dst_q;
  logic [7:0]           addr_q;
  logic [DW-1:0]        val_q;
  logic [DW-1:0]        regs_q [REG_COUNT];
  logic [DW-1:0]        a_q, b_q;
  logic signed [FW-1:0] res_q, res_d;
  trm_pkg::flags_t      flags_q, flags_d;
  logic [DW-1:0]        rd_data;
  logic [RW-1:0]        rd_idx;
  logic [DW-1:0]        wb_data;

  logic [DW-1:0]        dv_quot_q, dv_ub_q, dv_rem_q;
  logic                 dv_neg_q;
  logic [DW:0]          dv_sh;
  logic [DW:0]          dv_diff;
  logic                 dv_bit;

  logic [MEM_DEPTH-1:0] mvld_q;
  logic                 rd_vld_q;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  logic [DW-1:0]        ram_rdata, mem_data;

  logic signed [FW-1:0] sa, sb, prod;

  // Capture operands and reduce register indexes on a transfer
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      src_q  <= RW'(mod_by(DW'(item_i.src_reg), 9'(REG_COUNT)));
      dst_q  <= RW'(mod_by(DW'(item_i.dst_reg), 9'(REG_COUNT)));
      addr_q <= item_i.address;
      val_q  <= item_i.value;
    end
  end

  // Register read port, one index per step
  assign rd_idx  = (cw_i.rsel == trm_pkg::RS_DST) ? dst_q : src_q;
  assign rd_data = regs_q[rd_idx];

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      if (cw_i.lat == trm_pkg::LAT_A) begin
        a_q <= rd_data;
      end
      if (cw_i.lat == trm_pkg::LAT_B) begin
        b_q <= rd_data;
      end
    end
  end

  // Full-width arithmetic
  assign sa   = {{(FW-DW){a_q[DW-1]}}, a_q};
  assign sb   = {{(FW-DW){b_q[DW-1]}}, b_q};
  assign prod = $signed(a_q) * $signed(b_q);

  always_comb begin
    unique case (cw_i.alu)
      trm_pkg::ALU_VAL:  res_d = {{(FW-DW){val_q[DW-1]}}, val_q};
      trm_pkg::ALU_ADD:  res_d = sa + sb;
      trm_pkg::ALU_SUB:  res_d = sa - sb;
      trm_pkg::ALU_MUL:  res_d = prod;
      trm_pkg::ALU_INC:  res_d = sa + FW'(1);
      trm_pkg::ALU_DEC:  res_d = sa - FW'(1);
      trm_pkg::ALU_DIVF: res_d = dv_neg_q ? -$signed({{(FW-DW){1'b0}}, dv_quot_q})
                                          : $signed({{(FW-DW){1'b0}}, dv_quot_q});
      default:           res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      res_q <= res_d;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per step
  assign dv_sh   = {dv_rem_q, dv_quot_q[DW-1]};
  assign dv_diff = dv_sh - {1'b0, dv_ub_q};
  assign dv_bit  = (dv_sh >= {1'b0, dv_ub_q});

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      if (cw_i.alu == trm_pkg::ALU_DIVI) begin
        dv_quot_q <= a_q[DW-1] ? DW'(-a_q) : a_q;
        dv_ub_q   <= rd_data[DW-1] ? DW'(-rd_data) : rd_data;
        dv_rem_q  <= '0;
        dv_neg_q  <= a_q[DW-1] ^ rd_data[DW-1];
      end else if (cw_i.alu == trm_pkg::ALU_DIVS) begin
        dv_rem_q  <= dv_bit ? dv_diff[DW-1:0] : dv_sh[DW-1:0];
        dv_quot_q <= {dv_quot_q[DW-2:0], dv_bit};
      end
    end
  end

  // Flags from the full result before wrapping
  always_comb begin
    flags_d = flags_q;
    if (cw_i.wb == trm_pkg::WB_RES) begin
      flags_d.zf = (res_q[DW-1:0] == '0);
      flags_d.of = (res_q > FW'(signed'(127)));
      flags_d.uf = (res_q < -FW'(signed'(128)));
      flags_d.cf = flags_d.of | flags_d.uf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (step_en_i) begin
      flags_q <= flags_d;
    end
  end

  // Register write-back
  always_comb begin
    unique case (cw_i.wb)
      trm_pkg::WB_RES: wb_data = res_q[DW-1:0];
      trm_pkg::WB_VAL: wb_data = val_q;
      trm_pkg::WB_B:   wb_data = b_q;
      trm_pkg::WB_MEM: wb_data = mem_data;
      default:         wb_data = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
    end else if (step_en_i && (cw_i.wb != trm_pkg::WB_NONE)) begin
      regs_q[dst_q] <= wb_data;
    end
  end

  // Data memory; an entry never written reads as zero
  assign mem_re    = step_en_i && ((cw_i.mem == trm_pkg::MEM_RD_IND) ||
                                   (cw_i.mem == trm_pkg::MEM_RD_ADR));
  assign mem_we    = step_en_i && (cw_i.mem == trm_pkg::MEM_WR);
  assign mem_raddr = (cw_i.mem == trm_pkg::MEM_RD_IND) ?
                     AW'(mod_by(b_q, 9'(MEM_DEPTH))) : AW'(addr_q);
  assign mem_waddr = AW'(addr_q);

  trm_ram #(
    .WIDTH (DW),
    .DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        mvld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= mvld_q[mem_raddr];
      end
    end
  end

  assign mem_data = rd_vld_q ? ram_rdata : '0;

  // Conditions for the sequencer
  assign st_o.rd_zero  = (rd_data == '0);
  assign st_o.addr_oob = ({1'b0, addr_q} >= 9'(MEM_DEPTH));

  // Result of the final step
  always_comb begin
    unique case (cw_i.rv)
      trm_pkg::RV_B:   res_o.read_value = b_q;
      trm_pkg::RV_MEM: res_o.read_value = mem_data;
      default:         res_o.read_value = '0;
    endcase
  end
  assign res_o.flags = flags_d;
  assign res_o.error = cw_i.err;

endmodule

### rtl/tiny_register_machine_executor_unit.sv
// Top level of the register machine executor: stream ports and result register.
//
//  Port group  Dir   Transfer on            Contents
//  s_axis_*    in    tvalid & tready        one instruction
//  m_axis_*    out   tvalid & tready        one result per instruction
//
// Each instruction runs as a short microcode program, one control word per
// cycle while the output is not stalled. The bit-serial divider sets the
// worst case. A new instruction is taken the cycle after the previous one
// finishes, while its result may still wait in the output register; a full,
// stalled output register holds the final step. Reset clears registers,
// flags and memory valid bits at once.
module tiny_register_machine_executor_unit #(
  parameter int unsigned MEM_DEPTH = 64,
  parameter int unsigned REG_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] cmd, [6:4] src_reg, [9:7] dst_reg, [17:10] address, [25:18] value
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_value, [8] zero_flag, [9] carry_flag, [10] overflow_flag,
  // [11] underflow_flag, [13:12] error
  output logic [15:0] m_axis_tdata
);

  logic             busy;
  logic             start;
  logic             step_en;
  logic             out_stall;
  trm_pkg::cw_t     cw;
  trm_pkg::status_t st;
  trm_pkg::result_t res;
  trm_pkg::item_t   item;

  logic             m_vld_q, m_vld_d;
  logic [15:0]      m_data_q;

  // Unpack the instruction
  assign item.src_reg = s_axis_tdata[6:4];
  assign item.dst_reg = s_axis_tdata[9:7];
  assign item.address = s_axis_tdata[17:10];
  assign item.value   = s_axis_tdata[25:18];

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && !busy;
  assign out_stall     = m_vld_q && !m_axis_tready;

  trm_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (s_axis_tdata[3:0]),
    .st_i        (st),
    .out_stall_i (out_stall),
    .busy_o      (busy),
    .step_en_o   (step_en),
    .cw_o        (cw)
  );

  trm_datapath #(
    .MEM_DEPTH (MEM_DEPTH),
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .item_i    (item),
    .cw_i      (cw),
    .step_en_i (step_en),
    .st_o      (st),
    .res_o     (res)
  );

  // Load the result on the final step, drop it once transferred
  always_comb begin
    m_vld_d = m_vld_q;
    if (step_en && cw.done) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && cw.done) begin
      m_data_q <= {2'b00, res.error, res.flags.uf, res.flags.of, res.flags.cf,
                   res.flags.zf, res.read_value};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule
